[hdl/sbmq_pkg.sv]
`default_nettype none
package sbmq_pkg;

  localparam int ENTRIES = 16;
  localparam int QUEUES  = 4;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int QSEL_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int QNUM_W = 2;
  localparam int DATA_W = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } link_t;

  localparam int LINK_W = $bits(link_t);

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
    logic update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ok;
  } sts_t;

endpackage
`default_nettype wire

[hdl/shared_buffer_multi_queue.sv]
// a transaction is taken in the idle state, completed in the finish state, then presented from the output registers
// no new transaction is taken until the last one is finished, due to the read-then-write of the link memory
// a result waiting on the output holds the block in its finish state until taken
// reset: all queues empty, free list runs through entries 0 to the last in order,
// tracked by a fill mark, so no clearing pass; the data memory is not reset
`default_nettype none
module shared_buffer_multi_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // queue_num [1:0], data_in [33:2], zero [39:34]
  input  wire logic        s_axis_tuser,  // kind [0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // data_out [31:0]
  output logic      [1:0]  m_axis_tuser   // status [1:0]
);
  import sbmq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sbmq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (s_axis_tuser),
    .queue_num_i (s_axis_tdata[QNUM_W-1:0]),
    .data_in_i   (s_axis_tdata[QNUM_W+DATA_W-1:QNUM_W]),
    .status_o    (m_axis_tuser),
    .data_out_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

[hdl/sbmq_ram.sv]
`default_nettype none
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/sbmq_ctrl.sv]
`default_nettype none
module sbmq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sbmq_pkg::cmd_t     cmd_o,
  input  wire sbmq_pkg::sts_t sts_i
);
  import sbmq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      S_FINISH: begin
        cmd_o.commit = slot_free;
        cmd_o.update = slot_free && sts_i.ok;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_then_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == S_FINISH)
    else $error("accepted transaction did not move to finish");

  a_commit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not present a result");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |-> !cmd_o.accept && !in_ready_o)
    else $error("transaction accepted while an operation is open");

endmodule
`default_nettype wire

[hdl/sbmq_dp.sv]
`default_nettype none
module sbmq_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sbmq_pkg::cmd_t                cmd_i,
  output sbmq_pkg::sts_t                     sts_o,
  input  wire logic                          kind_i,
  input  wire logic [sbmq_pkg::QNUM_W-1:0]   queue_num_i,
  input  wire logic [sbmq_pkg::DATA_W-1:0]   data_in_i,
  output logic      [1:0]                    status_o,
  output logic      [sbmq_pkg::DATA_W-1:0]   data_out_o
);
  import sbmq_pkg::*;

  link_t             head_q [QUEUES];
  link_t             tail_q [QUEUES];
  link_t             free_q;
  logic [CNT_W-1:0]  fill_q;

  logic              op_kind_q;
  logic              op_ok_q;
  logic [QSEL_W-1:0] op_q;
  logic [IDX_W-1:0]  op_ent_q;

  status_e           out_status_q;
  logic [DATA_W-1:0] out_data_q;

  logic [QSEL_W-1:0] qi;
  logic              q_ok;
  link_t             hsel, tsel;
  logic              is_enq;
  logic              ok_a;
  logic [IDX_W-1:0]  ent_a;
  logic              enq_link_tail;

  logic              fresh;
  logic [31:0]       nxt;
  link_t             fresh_lnk, lnk;

  logic              link_we, link_re;
  logic [IDX_W-1:0]  link_waddr;
  link_t             link_wdata;
  logic [LINK_W-1:0] link_rdata;
  logic              data_we, data_re;
  logic [DATA_W-1:0] data_rdata;

  assign qi     = QSEL_W'(queue_num_i);
  assign q_ok   = 32'(queue_num_i) < QUEUES;
  assign hsel   = head_q[qi];
  assign tsel   = tail_q[qi];
  assign is_enq = (kind_i == OP_ENQ);
  assign ok_a   = q_ok && (is_enq ? free_q.vld : hsel.vld);
  assign ent_a  = is_enq ? free_q.idx : hsel.idx;
  assign enq_link_tail = cmd_i.accept && is_enq && ok_a && hsel.vld && tsel.vld;

  // entries at or above the fill mark were never taken and still hold their reset link
  assign fresh         = CNT_W'(op_ent_q) >= fill_q;
  assign nxt           = 32'(op_ent_q) + 32'd1;
  assign fresh_lnk.vld = nxt < ENTRIES;
  assign fresh_lnk.idx = IDX_W'(nxt);
  assign lnk           = fresh ? fresh_lnk : link_t'(link_rdata);

  always_comb begin
    link_we     = enq_link_tail || cmd_i.update;
    link_waddr  = tsel.idx;
    link_wdata  = '{vld: 1'b1, idx: ent_a};
    if (cmd_i.commit) begin
      link_waddr = op_ent_q;
      link_wdata = (op_kind_q == OP_ENQ) ? link_t'('0) : free_q;
    end
  end

  assign link_re = cmd_i.accept;
  assign data_we = cmd_i.accept && is_enq && ok_a;
  assign data_re = cmd_i.accept && !is_enq;

  sbmq_ram #(
    .WIDTH (LINK_W),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (ent_a),
    .rdata_o (link_rdata)
  );

  sbmq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (ent_a),
    .wdata_i (data_in_i),
    .re_i    (data_re),
    .raddr_i (ent_a),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      free_q    <= '{vld: 1'b1, idx: '0};
      fill_q    <= '0;
      op_kind_q <= OP_ENQ;
      op_ok_q   <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        op_kind_q <= kind_i;
        op_ok_q   <= ok_a;
        if (is_enq && ok_a) begin
          tail_q[qi] <= '{vld: 1'b1, idx: ent_a};
          if (!hsel.vld) begin
            head_q[qi] <= '{vld: 1'b1, idx: ent_a};
          end
        end
      end
      if (cmd_i.update) begin
        if (op_kind_q == OP_ENQ) begin
          free_q <= lnk;
          if (fresh) begin
            fill_q <= fill_q + CNT_W'(1);
          end
        end else begin
          head_q[op_q] <= lnk;
          free_q       <= '{vld: 1'b1, idx: op_ent_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= qi;
      op_ent_q <= ent_a;
    end
    if (cmd_i.commit) begin
      if (op_kind_q == OP_ENQ) begin
        out_status_q <= op_ok_q ? ST_OK : ST_FULL;
        out_data_q   <= '0;
      end else begin
        out_status_q <= op_ok_q ? ST_OK : ST_EMPTY;
        out_data_q   <= op_ok_q ? data_rdata : '1;
      end
    end
  end

  assign sts_o.ok   = op_ok_q;
  assign status_o   = out_status_q;
  assign data_out_o = out_data_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= ENTRIES)
    else $error("fill mark beyond the entry count");

  a_deq_frees_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && op_kind_q == OP_DEQ |=> free_q.vld)
    else $error("dequeue left the free list empty");

  a_refused_enq_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !op_ok_q && op_kind_q == OP_ENQ |=> out_status_q == ST_FULL)
    else $error("refused enqueue not reported as full");

  a_update_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> op_ok_q && cmd_i.commit)
    else $error("state update on a refused operation");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb;
  import sbmq_pkg::*;

  typedef struct {
    status_e     status;
    logic [31:0] data;
  } queue_result_t;

  typedef struct {
    op_kind_e      op;
    logic [1:0]    qn;
    logic [31:0]   din;
    bit            fixed;
    queue_result_t want;
  } directed_row_t;

  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 60;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 80;
  localparam int SEGMENT      = 25;
  localparam int TAIL_CYCLES  = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // queue_num [1:0], data_in [33:2], zero [39:34]
  logic        s_axis_tuser;   // kind [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // data_out [31:0]
  logic [1:0]  m_axis_tuser;   // status [1:0]

  // shadow of the shared store: per-queue head/tail, next links, data words, free list
  link_t       q_head [QUEUES];
  link_t       q_tail [QUEUES];
  link_t       next_link [ENTRIES];
  logic [31:0] word_store [ENTRIES];
  link_t       free_ptr;

  queue_result_t pending_results [$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            long_hold_req = 1'b0;
  bit            rx_stalls_on = 1'b1;

  shared_buffer_multi_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic queue_result_t apply_queue_op(input op_kind_e op, input logic [1:0] qn,
                                                   input logic [31:0] din);
    queue_result_t  res;
    logic [IDX_W-1:0] e;
    if (op == OP_ENQ) begin
      res.status = ST_OK;
      res.data   = '0;
      if (qn >= QUEUES || !free_ptr.vld) begin
        res.status = ST_FULL;
      end else begin
        e        = free_ptr.idx;
        free_ptr = next_link[e];
        // an empty queue is recognized by its head, so a stale tail is never followed
        if (!q_head[qn].vld) begin
          q_head[qn] = '{vld: 1'b1, idx: e};
        end else begin
          next_link[q_tail[qn].idx] = '{vld: 1'b1, idx: e};
        end
        next_link[e]  = '0;
        q_tail[qn]    = '{vld: 1'b1, idx: e};
        word_store[e] = din;
      end
    end else begin
      if (qn >= QUEUES || !q_head[qn].vld) begin
        res.status = ST_EMPTY;
        res.data   = '1;
      end else begin
        e            = q_head[qn].idx;
        q_head[qn]   = next_link[e];
        next_link[e] = free_ptr;
        free_ptr     = '{vld: 1'b1, idx: e};
        res.status   = ST_OK;
        res.data     = word_store[e];
      end
    end
    return res;
  endfunction

  task automatic send_item(input op_kind_e op, input logic [1:0] qn, input logic [31:0] din,
                           input bit fixed, input queue_result_t want);
    queue_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, din, qn};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_queue_op(op, qn, din);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  task automatic tx_idle(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%h", $time, m_axis_tuser,
                 m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                   m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata !== want.data) begin
          $display("%0t: data mismatch expected=%h actual=%h", $time, want.data,
                   m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rx_side
    int n;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    directed_row_t rows [$];
    op_kind_e      op;
    logic [1:0]    qn;
    logic [31:0]   din;
    int            enq_pct;
    int            fav_q;
    bit            seg_idle;

    for (int q = 0; q < QUEUES; q++) begin
      q_head[q] = '0;
      q_tail[q] = '0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      next_link[i]  = '{vld: (i + 1 < ENTRIES), idx: IDX_W'(i + 1)};
      word_store[i] = '0;
    end
    free_ptr = '{vld: 1'b1, idx: '0};

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ENQ;

    rows.push_back('{OP_DEQ, 2'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'hFFFF_FFFF}});
    rows.push_back('{OP_ENQ, 2'd0, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0}});
    rows.push_back('{OP_ENQ, 2'd3, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0}});
    rows.push_back('{OP_DEQ, 2'd3, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h8000_0000}});
    // queue 3 drained, tail left stale
    rows.push_back('{OP_DEQ, 2'd3, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'hFFFF_FFFF}});
    rows.push_back('{OP_ENQ, 2'd3, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0}});
    rows.push_back('{OP_DEQ, 2'd3, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0}});
    rows.push_back('{OP_DEQ, 2'd0, 32'h0000_0000, 1'b1, '{ST_OK, 32'h7FFF_FFFF}});
    // fill the whole store over two queues, then one enqueue too many
    for (int i = 0; i < ENTRIES; i++) begin
      rows.push_back('{OP_ENQ, 2'(1 + i % 2), 32'hA5A5_0000 ^ (32'h1111_1111 * i), 1'b0,
                       '{ST_OK, 32'h0}});
    end
    rows.push_back('{OP_ENQ, 2'd2, 32'hFFFF_FFFF, 1'b1, '{ST_FULL, 32'h0}});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].qn, rows[i].din, rows[i].fixed, rows[i].want);
    end

    // let the block drain completely before the random part
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT == 0) begin
        enq_pct      = $urandom_range(15, 85);
        fav_q        = $urandom_range(0, QUEUES);
        seg_idle     = ($urandom_range(0, 3) != 0) && (i < RANDOM_ITEMS - CALM_ITEMS);
        rx_stalls_on = seg_idle;
      end
      if (i == RANDOM_ITEMS - CALM_ITEMS) begin
        seg_idle     = 1'b0;
        rx_stalls_on = 1'b0;
      end
      // output held off while items keep coming, so the input backs up
      if (i == 100) long_hold_req = 1'b1;
      if (i == 250) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
      end

      op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
      if (fav_q < QUEUES && $urandom_range(0, 9) < 7) begin
        qn = 2'(fav_q);
      end else begin
        qn = 2'($urandom_range(0, QUEUES - 1));
      end
      case ($urandom_range(0, 9))
        0: din = 32'h8000_0000;
        1: din = 32'h7FFF_FFFF;
        2: din = 32'hFFFF_FFFF;
        3: din = 32'h0000_0000;
        default: din = $urandom;
      endcase

      send_item(op, qn, din, 1'b0, '{ST_OK, 32'h0});
      if (seg_idle && $urandom_range(0, 4) == 0) tx_idle($urandom_range(1, 9));
    end

    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
